>>> rtl/lit_pkg.sv
`timescale 1ns / 1ps
// Package for the local interrupt timer: command codes, register offsets,
// transaction types and the divide-configuration decode. No dependencies.
package lit_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int PSC_WIDTH       = 7;
    localparam int LIM_WIDTH       = PSC_WIDTH + 1;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    localparam logic [11:0] OFF_SPURIOUS = 12'h0f0;
    localparam logic [11:0] OFF_TIMER    = 12'h320;
    localparam logic [11:0] OFF_INITIAL  = 12'h380;
    localparam logic [11:0] OFF_CURRENT  = 12'h390;
    localparam logic [11:0] OFF_DIVIDE   = 12'h3e0;

    localparam int ENTRY_MASK_BIT     = 16;
    localparam int ENTRY_PERIODIC_BIT = 17;
    localparam int SPUR_ENABLE_BIT    = 8;
    localparam logic [3:0] DIV_BITS   = 4'hb;
    localparam logic [8:0] SPUR_RESET = 9'h0ff;

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] reg_offset;
        logic [31:0] write_data;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_valid;
        logic [7:0]  irq_vector;
    } result_t;

    // Prescale limit: bits 3,1,0 select /2 .. /128, all ones selects /1.
    function automatic logic [LIM_WIDTH-1:0] div_limit(input logic [3:0] d);
        logic [2:0] sel;
        sel = {d[3], d[1:0]};
        if (sel == 3'b111) begin
            return LIM_WIDTH'(1);
        end
        return LIM_WIDTH'(LIM_WIDTH'(2) << sel);
    endfunction

endpackage

>>> rtl/local_interrupt_timer.sv
`timescale 1ns / 1ps
// Local interrupt timer top level: input register, timer core, result register.
// Ticks, writes and reads interleave freely.
// Throughput: one transaction per cycle while the m_ side does not stall.
// The input stage advances whenever the result register is empty or being drained.
// Reset (aresetn low, synchronous): both stages empty, timer masked and one-shot,
// counts and divide zero, unit disabled with spurious vector 0xff.
module local_interrupt_timer #(
    parameter int COUNT_WIDTH = lit_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [11:0] s_reg_offset,
    input  logic [31:0] s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_irq_valid,
    output logic [7:0]  m_irq_vector
);

    // Input stage: holds one accepted transaction until the core processes it.
    logic              in_valid_reg;
    lit_pkg::item_t    in_item_reg;
    // Result stage: holds one finished result until the sink takes it.
    logic              out_valid_reg;
    lit_pkg::result_t  out_res_reg;
    lit_pkg::result_t  core_res;
    logic              out_free;
    logic              advance;

    // Result register can take a new value when empty or drained this cycle.
    assign out_free = !out_valid_reg || m_ready;
    // Process the staged transaction: state updates and result load together.
    assign advance  = in_valid_reg && out_free;
    // Accept a new transaction whenever the input stage empties this cycle.
    assign s_ready  = !in_valid_reg || out_free;

    lit_regs #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_regs (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (advance),
        .item   (in_item_reg),
        .result (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Payload needs no reset; load on acceptance only.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.command    <= s_command;
            in_item_reg.reg_offset <= s_reg_offset;
            in_item_reg.write_data <= s_write_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_read_data  = out_res_reg.read_data;
    assign m_irq_valid  = out_res_reg.irq_valid;
    assign m_irq_vector = out_res_reg.irq_vector;

endmodule

>>> rtl/lit_regs.sv
`timescale 1ns / 1ps
// Timer state and register file of the local interrupt timer. Computes the
// result of one transaction and updates state when enabled. Uses lit_pkg.
module lit_regs #(
    parameter int COUNT_WIDTH = lit_pkg::COUNT_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  lit_pkg::item_t   item,
    output lit_pkg::result_t result
);

    logic [7:0]                     vec_reg, vec_next;
    logic                           mask_reg, mask_next;
    logic                           per_reg, per_next;
    logic [COUNT_WIDTH-1:0]         init_reg, init_next;
    logic [COUNT_WIDTH-1:0]         cur_reg, cur_next;
    logic [3:0]                     div_reg, div_next;
    logic [lit_pkg::PSC_WIDTH-1:0]  psc_reg, psc_next;
    logic [8:0]                     spur_reg, spur_next;
    logic [COUNT_WIDTH-1:0]         dec;
    logic [lit_pkg::LIM_WIDTH-1:0]  lim;

    assign lim = lit_pkg::div_limit(div_reg);
    assign dec = cur_reg - COUNT_WIDTH'(1);

    always_comb begin
        vec_next  = vec_reg;
        mask_next = mask_reg;
        per_next  = per_reg;
        init_next = init_reg;
        cur_next  = cur_reg;
        div_next  = div_reg;
        psc_next  = psc_reg;
        spur_next = spur_reg;
        result    = '0;
        case (item.command)
            lit_pkg::CMD_TICK: begin
                if (cur_reg != '0) begin
                    if ({1'b0, psc_reg} + lit_pkg::LIM_WIDTH'(1) >= lim) begin
                        psc_next = '0;
                        if (dec == '0) begin
                            cur_next = per_reg ? init_reg : '0;
                            if (!mask_reg && spur_reg[lit_pkg::SPUR_ENABLE_BIT]) begin
                                result.irq_valid  = 1'b1;
                                result.irq_vector = vec_reg;
                            end
                        end else begin
                            cur_next = dec;
                        end
                    end else begin
                        psc_next = psc_reg + lit_pkg::PSC_WIDTH'(1);
                    end
                end else begin
                    psc_next = '0;
                end
            end
            lit_pkg::CMD_WRITE: begin
                case (item.reg_offset)
                    lit_pkg::OFF_SPURIOUS: spur_next = item.write_data[8:0];
                    lit_pkg::OFF_TIMER: begin
                        vec_next  = item.write_data[7:0];
                        mask_next = item.write_data[lit_pkg::ENTRY_MASK_BIT];
                        per_next  = item.write_data[lit_pkg::ENTRY_PERIODIC_BIT];
                    end
                    lit_pkg::OFF_INITIAL: begin
                        init_next = item.write_data[COUNT_WIDTH-1:0];
                        cur_next  = item.write_data[COUNT_WIDTH-1:0];
                        psc_next  = '0;
                    end
                    lit_pkg::OFF_DIVIDE: div_next = item.write_data[3:0] & lit_pkg::DIV_BITS;
                    default: ;
                endcase
            end
            lit_pkg::CMD_READ: begin
                case (item.reg_offset)
                    lit_pkg::OFF_SPURIOUS: result.read_data = 32'(spur_reg);
                    lit_pkg::OFF_TIMER: begin
                        result.read_data = '0;
                        result.read_data[7:0] = vec_reg;
                        result.read_data[lit_pkg::ENTRY_MASK_BIT]     = mask_reg;
                        result.read_data[lit_pkg::ENTRY_PERIODIC_BIT] = per_reg;
                    end
                    lit_pkg::OFF_INITIAL: result.read_data = 32'(init_reg);
                    lit_pkg::OFF_CURRENT: result.read_data = 32'(cur_reg);
                    lit_pkg::OFF_DIVIDE:  result.read_data = 32'(div_reg);
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_reg  <= '0;
            mask_reg <= 1'b1;
            per_reg  <= 1'b0;
            init_reg <= '0;
            cur_reg  <= '0;
            div_reg  <= '0;
            psc_reg  <= '0;
            spur_reg <= lit_pkg::SPUR_RESET;
        end else if (en) begin
            vec_reg  <= vec_next;
            mask_reg <= mask_next;
            per_reg  <= per_next;
            init_reg <= init_next;
            cur_reg  <= cur_next;
            div_reg  <= div_next;
            psc_reg  <= psc_next;
            spur_reg <= spur_next;
        end
    end

endmodule

>>> rtl/lit_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the local interrupt timer, bound to the top level.
// Depends only on the top level's result-channel ports.
module lit_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_read_data,
    input logic        m_irq_valid,
    input logic [7:0]  m_irq_vector
);

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data)
            && $stable(m_irq_valid) && $stable(m_irq_vector))
        else $error("stalled result changed");

    // Vector is zero unless an interrupt is raised.
    a_vec_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_irq_valid |-> m_irq_vector == 8'd0)
        else $error("vector without interrupt");

    // Only ticks raise interrupts, and ticks return no read data.
    a_irq_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_irq_valid |-> m_read_data == 32'd0)
        else $error("interrupt together with read data");

endmodule

bind local_interrupt_timer lit_checker u_lit_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_read_data (m_read_data),
    .m_irq_valid (m_irq_valid),
    .m_irq_vector(m_irq_vector)
);
